### hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_W          = 24;
	localparam int FIELD_W         = 22;
	localparam int STATUS_W        = 3;
	localparam int GRANULE         = 16;
	localparam int HEAP_BYTES_DEF  = 2097152;
	localparam int MAX_FREE_DEF    = 64;
	localparam int MAX_LIVE_DEF    = 256;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_ZERO_SIZE    = 3'd1,
		ST_NO_FIT       = 3'd2,
		ST_INVALID_FREE = 3'd3,
		ST_TABLE_FULL   = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	// One extent: header start and payload size in bytes.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
	} ext_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_SLOT_STEP,
		DP_FIT_STEP,
		DP_ALLOC_COMMIT,
		DP_SHIFT_DN,
		DP_COUNT_DEC,
		DP_USED_STEP,
		DP_USED_TAKE,
		DP_POS_STEP,
		DP_POS_TAKE,
		DP_MERGE_BOTH,
		DP_MERGE_PREV,
		DP_MERGE_NEXT,
		DP_INS_START,
		DP_SHIFT_UP,
		DP_INS_DONE,
		DP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic req_zero;
		logic off_zero;
		logic slot_free;
		logic slot_last;
		logic f_more;
		logic f_pend;
		logic fit_hit;
		logic split;
		logic u_more;
		logic u_hit;
		logic pos_stop;
		logic mp;
		logic mn;
		logic list_full;
		logic up_more;
		logic out_busy;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_SLOT,
		S_FIT,
		S_SHDN,
		S_USCAN,
		S_POS,
		S_MERGE,
		S_SHUP,
		S_RESP
	} state_t;

endpackage

### hdl/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channels of the allocator: request items and result items.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [ffha_pkg::FIELD_W-1:0] request_bytes;
	logic [ffha_pkg::FIELD_W-1:0] block_offset;

	modport source (output valid, kind, request_bytes, block_offset, input ready);
	modport sink (input valid, kind, request_bytes, block_offset, output ready);
endinterface

interface ffha_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffha_pkg::FIELD_W-1:0]  user_offset;
	logic [ffha_pkg::STATUS_W-1:0] status;

	modport source (output valid, user_offset, status, input ready);
	modport sink (input valid, user_offset, status, output ready);
endinterface

### hdl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with an address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                               | Handshake
//  --------+-----+---------------------------------------+-------------
//  req     | in  | kind, request_bytes, block_offset     | valid/ready
//  rsp     | out | user_offset, status                   | valid/ready
//
// One item is worked at a time, and every item gives exactly one result item.
// An allocate scans the live-slot flags for a free slot (up to MAX_LIVE_BLOCKS),
// walks the free-extent RAM for a fit (one entry a cycle) and shifts the list
// down to close a consumed extent. A free walks the live-block RAM (up to
// MAX_LIVE_BLOCKS entries), plus up to two walks of the free list for the
// position search and a shift. Reset is asynchronous and needs no clearing
// pass; the next request is taken while a result waits.
//
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES       = ffha_pkg::HEAP_BYTES_DEF,
	parameter int MAX_FREE_EXTENTS = ffha_pkg::MAX_FREE_DEF,
	parameter int MAX_LIVE_BLOCKS  = ffha_pkg::MAX_LIVE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ffha_req_if.sink  req,
	ffha_rsp_if.source rsp
);

	// Commands flow from the sequencer; status flags flow back.
	ffha_pkg::dp_cmd_t  cmd;
	ffha_pkg::dp_stat_t stat;

	// The sequencer owns the request handshake and orders the scans.
	ffha_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// The datapath holds both tables, the live flags and the result register.
	ffha_dp #(
		.HEAP_BYTES(HEAP_BYTES),
		.MAX_FREE_EXTENTS(MAX_FREE_EXTENTS),
		.MAX_LIVE_BLOCKS(MAX_LIVE_BLOCKS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_kind(req.kind),
		.in_request_bytes(req.request_bytes),
		.in_block_offset(req.block_offset),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_user_offset(rsp.user_offset),
		.out_status(rsp.status)
	);

endmodule

### hdl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: walks each item through its scans and updates.
// ----------------------------------------------------------------------------
module ffha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ffha_pkg::dp_stat_t  stat,
	output ffha_pkg::dp_cmd_t   cmd
);

	ffha_pkg::state_t  state_q, state_d;
	ffha_pkg::status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_IDLE;
			st_q    <= ffha_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	// Next state and the status that will be reported.
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (in_valid) state_d = ffha_pkg::S_DISP;
			end
			ffha_pkg::S_DISP: begin
				st_d = ffha_pkg::ST_OK;
				if (!stat.is_free) begin
					if (stat.req_zero) begin
						st_d    = ffha_pkg::ST_ZERO_SIZE;
						state_d = ffha_pkg::S_RESP;
					end else begin
						state_d = ffha_pkg::S_SLOT;
					end
				end else if (stat.off_zero) begin
					state_d = ffha_pkg::S_RESP;
				end else begin
					state_d = ffha_pkg::S_USCAN;
				end
			end
			ffha_pkg::S_SLOT: begin
				if (stat.slot_free) begin
					state_d = ffha_pkg::S_FIT;
				end else if (stat.slot_last) begin
					st_d    = ffha_pkg::ST_TABLE_FULL;
					state_d = ffha_pkg::S_RESP;
				end
			end
			ffha_pkg::S_FIT: begin
				if (stat.fit_hit) begin
					state_d = stat.split ? ffha_pkg::S_RESP : ffha_pkg::S_SHDN;
				end else if (!stat.f_more) begin
					st_d    = ffha_pkg::ST_NO_FIT;
					state_d = ffha_pkg::S_RESP;
				end
			end
			ffha_pkg::S_SHDN: begin
				if (!stat.f_more && !stat.f_pend) state_d = ffha_pkg::S_RESP;
			end
			ffha_pkg::S_USCAN: begin
				if (stat.u_hit) begin
					state_d = ffha_pkg::S_POS;
				end else if (!stat.u_more) begin
					st_d    = ffha_pkg::ST_INVALID_FREE;
					state_d = ffha_pkg::S_RESP;
				end
			end
			ffha_pkg::S_POS: begin
				if (stat.pos_stop || !stat.f_more) state_d = ffha_pkg::S_MERGE;
			end
			ffha_pkg::S_MERGE: begin
				if (stat.mp && stat.mn) begin
					state_d = ffha_pkg::S_SHDN;
				end else if (stat.mp || stat.mn) begin
					state_d = ffha_pkg::S_RESP;
				end else if (stat.list_full) begin
					st_d    = ffha_pkg::ST_TABLE_FULL;
					state_d = ffha_pkg::S_RESP;
				end else begin
					state_d = ffha_pkg::S_SHUP;
				end
			end
			ffha_pkg::S_SHUP: begin
				if (!stat.up_more && !stat.f_pend) state_d = ffha_pkg::S_RESP;
			end
			ffha_pkg::S_RESP: begin
				if (!stat.out_busy) state_d = ffha_pkg::S_IDLE;
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		in_ready   = 1'b0;
		cmd.op     = ffha_pkg::DP_NONE;
		cmd.status = st_q;
		case (state_q)
			ffha_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = ffha_pkg::DP_LOAD;
			end
			ffha_pkg::S_SLOT: cmd.op = ffha_pkg::DP_SLOT_STEP;
			ffha_pkg::S_FIT: begin
				if (stat.fit_hit) cmd.op = ffha_pkg::DP_ALLOC_COMMIT;
				else if (stat.f_more) cmd.op = ffha_pkg::DP_FIT_STEP;
			end
			ffha_pkg::S_SHDN: begin
				if (!stat.f_more && !stat.f_pend) cmd.op = ffha_pkg::DP_COUNT_DEC;
				else cmd.op = ffha_pkg::DP_SHIFT_DN;
			end
			ffha_pkg::S_USCAN: begin
				if (stat.u_hit) cmd.op = ffha_pkg::DP_USED_TAKE;
				else if (stat.u_more) cmd.op = ffha_pkg::DP_USED_STEP;
			end
			ffha_pkg::S_POS: begin
				if (stat.pos_stop) cmd.op = ffha_pkg::DP_POS_TAKE;
				else cmd.op = ffha_pkg::DP_POS_STEP;
			end
			ffha_pkg::S_MERGE: begin
				if (stat.mp && stat.mn) cmd.op = ffha_pkg::DP_MERGE_BOTH;
				else if (stat.mp) cmd.op = ffha_pkg::DP_MERGE_PREV;
				else if (stat.mn) cmd.op = ffha_pkg::DP_MERGE_NEXT;
				else if (!stat.list_full) cmd.op = ffha_pkg::DP_INS_START;
			end
			ffha_pkg::S_SHUP: begin
				if (!stat.up_more && !stat.f_pend) cmd.op = ffha_pkg::DP_INS_DONE;
				else cmd.op = ffha_pkg::DP_SHIFT_UP;
			end
			ffha_pkg::S_RESP: begin
				if (!stat.out_busy) cmd.op = ffha_pkg::DP_RESULT;
			end
			default: cmd.op = ffha_pkg::DP_NONE;
		endcase
	end

endmodule

### hdl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Allocator datapath: free-extent RAM, live-block RAM, live flags, scan
// counters, merge arithmetic and the result register.
// ----------------------------------------------------------------------------
module ffha_dp #(
	parameter int HEAP_BYTES       = ffha_pkg::HEAP_BYTES_DEF,
	parameter int MAX_FREE_EXTENTS = ffha_pkg::MAX_FREE_DEF,
	parameter int MAX_LIVE_BLOCKS  = ffha_pkg::MAX_LIVE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffha_pkg::dp_cmd_t             cmd,
	output ffha_pkg::dp_stat_t            stat,
	input  logic                          in_kind,
	input  logic [ffha_pkg::FIELD_W-1:0]  in_request_bytes,
	input  logic [ffha_pkg::FIELD_W-1:0]  in_block_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffha_pkg::FIELD_W-1:0]  out_user_offset,
	output logic [ffha_pkg::STATUS_W-1:0] out_status
);

	localparam int AW  = ffha_pkg::ADDR_W;
	localparam int FW  = ffha_pkg::FIELD_W;
	localparam int EW  = $bits(ffha_pkg::ext_t);
	localparam int FCW = $clog2(MAX_FREE_EXTENTS + 1);
	localparam int FAW = $clog2(MAX_FREE_EXTENTS);
	localparam int UCW = $clog2(MAX_LIVE_BLOCKS + 1);
	localparam int UAW = $clog2(MAX_LIVE_BLOCKS);
	localparam logic [AW-1:0] G    = AW'(ffha_pkg::GRANULE);
	localparam logic [AW-1:0] GM1  = AW'(ffha_pkg::GRANULE - 1);
	localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - ffha_pkg::GRANULE);

	// Control state.
	logic [FCW-1:0]             fidx_q, count_q, pos_q;
	logic [FAW-1:0]             frd_idx_q;
	logic                       frd_pend_q;
	logic [UCW-1:0]             uidx_q;
	logic [UAW-1:0]             urd_idx_q;
	logic                       urd_pend_q;
	logic [MAX_LIVE_BLOCKS-1:0] valid_q;
	logic                       init0_q;
	logic                       has_next_q;
	logic                       out_valid_q;

	// Payload registers.
	logic                       kind_q;
	logic [AW-1:0]              need_q, off_q;
	logic                       req_zero_q;
	logic [UAW-1:0]             slot_q;
	ffha_pkg::ext_t             blk_q, prev_q, next_q;
	logic [FW-1:0]              grant_q;
	logic [FW-1:0]              out_offset_q;
	logic [ffha_pkg::STATUS_W-1:0] out_status_q;

	// RAM ports.
	logic           f_we, f_re, u_we, u_re;
	logic [FAW-1:0] f_waddr, f_raddr;
	ffha_pkg::ext_t f_wdata, f_rdata_raw, f_rd, u_wdata, u_rd;

	// Derived values.
	logic [AW-1:0]  rem, blk_end;
	logic [FAW-1:0] pos_m1;
	logic           f_more, up_more, u_more, u_hit, fit_hit, pos_stop;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_EXTENTS)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.re(f_re), .raddr(f_raddr), .rdata(f_rdata_raw)
	);

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_LIVE_BLOCKS)) u_used_ram (
		.clk(clk), .we(u_we), .waddr(slot_q), .wdata(u_wdata),
		.re(u_re), .raddr(uidx_q[UAW-1:0]), .rdata(u_rd)
	);

	// Entry 0 reads as the whole heap until it is first written.
	always_comb begin
		f_rd = f_rdata_raw;
		if (init0_q && frd_idx_q == '0) begin
			f_rd.start = '0;
			f_rd.size  = INIT_SIZE;
		end
	end

	assign rem      = f_rd.size - need_q;
	assign blk_end  = blk_q.start + G + blk_q.size;
	assign pos_m1   = FAW'(pos_q - FCW'(1));
	assign f_more   = fidx_q < count_q;
	assign up_more  = fidx_q > pos_q;
	assign u_more   = uidx_q < UCW'(MAX_LIVE_BLOCKS);
	assign fit_hit  = frd_pend_q && (f_rd.size >= need_q);
	assign pos_stop = frd_pend_q && (f_rd.start >= blk_q.start);
	assign u_hit    = urd_pend_q && valid_q[urd_idx_q] && (u_rd.start + G == off_q);

	always_comb begin
		stat.is_free   = kind_q == ffha_pkg::KIND_FREE;
		stat.req_zero  = req_zero_q;
		stat.off_zero  = off_q == '0;
		stat.slot_free = !valid_q[uidx_q[UAW-1:0]];
		stat.slot_last = uidx_q == UCW'(MAX_LIVE_BLOCKS - 1);
		stat.f_more    = f_more;
		stat.f_pend    = frd_pend_q;
		stat.fit_hit   = fit_hit;
		stat.split     = rem > G;
		stat.u_more    = u_more;
		stat.u_hit     = u_hit;
		stat.pos_stop  = pos_stop;
		stat.mp        = (pos_q != '0) && (prev_q.start + G + prev_q.size == blk_q.start);
		stat.mn        = has_next_q && (next_q.start == blk_end);
		stat.list_full = count_q == FCW'(MAX_FREE_EXTENTS);
		stat.up_more   = up_more;
		stat.out_busy  = out_valid_q && !out_ready;
	end

	// RAM access per command.
	always_comb begin
		f_we          = 1'b0;
		f_re          = 1'b0;
		f_waddr       = frd_idx_q;
		f_raddr       = fidx_q[FAW-1:0];
		f_wdata       = f_rd;
		u_we          = 1'b0;
		u_re          = 1'b0;
		u_wdata.start = f_rd.start;
		u_wdata.size  = need_q;
		case (cmd.op)
			ffha_pkg::DP_FIT_STEP, ffha_pkg::DP_POS_STEP: f_re = f_more;
			ffha_pkg::DP_SHIFT_DN: begin
				f_re    = f_more;
				f_we    = frd_pend_q;
				f_waddr = frd_idx_q - FAW'(1);
			end
			ffha_pkg::DP_SHIFT_UP: begin
				f_re    = up_more;
				f_raddr = FAW'(fidx_q - FCW'(1));
				f_we    = frd_pend_q;
				f_waddr = frd_idx_q + FAW'(1);
			end
			ffha_pkg::DP_ALLOC_COMMIT: begin
				u_we          = 1'b1;
				f_we          = rem > G;
				f_wdata.start = f_rd.start + G + need_q;
				f_wdata.size  = rem - G;
			end
			ffha_pkg::DP_USED_STEP: u_re = u_more;
			ffha_pkg::DP_MERGE_BOTH: begin
				f_we          = 1'b1;
				f_waddr       = pos_m1;
				f_wdata.start = prev_q.start;
				f_wdata.size  = prev_q.size + G + blk_q.size + G + next_q.size;
			end
			ffha_pkg::DP_MERGE_PREV: begin
				f_we          = 1'b1;
				f_waddr       = pos_m1;
				f_wdata.start = prev_q.start;
				f_wdata.size  = prev_q.size + G + blk_q.size;
			end
			ffha_pkg::DP_MERGE_NEXT: begin
				f_we          = 1'b1;
				f_waddr       = pos_q[FAW-1:0];
				f_wdata.start = blk_q.start;
				f_wdata.size  = blk_q.size + G + next_q.size;
			end
			ffha_pkg::DP_INS_DONE: begin
				f_we    = 1'b1;
				f_waddr = pos_q[FAW-1:0];
				f_wdata = blk_q;
			end
			default: f_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q      <= '0;
			count_q     <= FCW'(1);
			pos_q       <= '0;
			frd_idx_q   <= '0;
			frd_pend_q  <= 1'b0;
			uidx_q      <= '0;
			urd_idx_q   <= '0;
			urd_pend_q  <= 1'b0;
			valid_q     <= '0;
			init0_q     <= 1'b1;
			has_next_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (f_we && f_waddr == '0) init0_q <= 1'b0;
			if (cmd.op == ffha_pkg::DP_RESULT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				ffha_pkg::DP_LOAD: begin
					fidx_q     <= '0;
					uidx_q     <= '0;
					frd_pend_q <= 1'b0;
					urd_pend_q <= 1'b0;
				end
				ffha_pkg::DP_SLOT_STEP: uidx_q <= uidx_q + UCW'(1);
				ffha_pkg::DP_FIT_STEP, ffha_pkg::DP_SHIFT_DN: begin
					if (f_more) begin
						fidx_q    <= fidx_q + FCW'(1);
						frd_idx_q <= fidx_q[FAW-1:0];
					end
					frd_pend_q <= f_more;
				end
				ffha_pkg::DP_POS_STEP: begin
					if (f_more) begin
						fidx_q    <= fidx_q + FCW'(1);
						frd_idx_q <= fidx_q[FAW-1:0];
					end
					frd_pend_q <= f_more;
					pos_q      <= count_q;
					has_next_q <= 1'b0;
				end
				ffha_pkg::DP_POS_TAKE: begin
					pos_q      <= FCW'(frd_idx_q);
					has_next_q <= 1'b1;
				end
				ffha_pkg::DP_ALLOC_COMMIT: begin
					valid_q[slot_q] <= 1'b1;
					fidx_q          <= FCW'(frd_idx_q) + FCW'(1);
					frd_pend_q      <= 1'b0;
				end
				ffha_pkg::DP_COUNT_DEC: count_q <= count_q - FCW'(1);
				ffha_pkg::DP_USED_STEP: begin
					if (u_more) begin
						uidx_q    <= uidx_q + UCW'(1);
						urd_idx_q <= uidx_q[UAW-1:0];
					end
					urd_pend_q <= u_more;
				end
				ffha_pkg::DP_USED_TAKE: begin
					fidx_q     <= '0;
					frd_pend_q <= 1'b0;
				end
				ffha_pkg::DP_MERGE_BOTH: begin
					valid_q[slot_q] <= 1'b0;
					fidx_q          <= pos_q + FCW'(1);
					frd_pend_q      <= 1'b0;
				end
				ffha_pkg::DP_MERGE_PREV, ffha_pkg::DP_MERGE_NEXT: valid_q[slot_q] <= 1'b0;
				ffha_pkg::DP_INS_START: begin
					fidx_q     <= count_q;
					frd_pend_q <= 1'b0;
				end
				ffha_pkg::DP_SHIFT_UP: begin
					if (up_more) begin
						fidx_q    <= fidx_q - FCW'(1);
						frd_idx_q <= FAW'(fidx_q - FCW'(1));
					end
					frd_pend_q <= up_more;
				end
				ffha_pkg::DP_INS_DONE: begin
					valid_q[slot_q] <= 1'b0;
					count_q         <= count_q + FCW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::DP_LOAD: begin
				kind_q     <= in_kind;
				off_q      <= AW'(in_block_offset);
				need_q     <= (AW'(in_request_bytes) + GM1) & ~GM1;
				req_zero_q <= in_request_bytes == '0;
				grant_q    <= '0;
			end
			ffha_pkg::DP_SLOT_STEP: slot_q <= uidx_q[UAW-1:0];
			ffha_pkg::DP_ALLOC_COMMIT: grant_q <= FW'(f_rd.start + G);
			ffha_pkg::DP_USED_TAKE: begin
				blk_q  <= u_rd;
				slot_q <= urd_idx_q;
			end
			ffha_pkg::DP_POS_STEP: begin
				if (frd_pend_q) prev_q <= f_rd;
			end
			ffha_pkg::DP_POS_TAKE: next_q <= f_rd;
			ffha_pkg::DP_RESULT: begin
				out_offset_q <= grant_q;
				out_status_q <= cmd.status;
			end
			default: slot_q <= slot_q;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign out_user_offset = out_offset_q;
	assign out_status      = out_status_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FCW'(MAX_FREE_EXTENTS))
		else $error("free extent count beyond table depth");

	a_commit_sets_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == ffha_pkg::DP_ALLOC_COMMIT |=> valid_q[$past(slot_q)])
		else $error("granted slot not marked live");

	a_result_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == ffha_pkg::DP_RESULT |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

	a_init_stays_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init0_q |=> !init0_q)
		else $error("entry zero reset flag set again");
`endif

endmodule
